### hw/rtl/u8u16_pkg.sv
// Shared constants and types for the UTF-8 to UTF-16 transcoder.
// No dependencies; used by the top level.
`default_nettype none

package u8u16_pkg;

    // Replacement unit for every rejected sequence.
    localparam logic [15:0] REPL_UNIT  = 16'hFFFD;
    localparam logic [20:0] MAX_CP     = 21'h10FFFF;
    localparam logic [20:0] SURR_FIRST = 21'h00D800;
    localparam logic [20:0] SURR_LAST  = 21'h00DFFF;
    localparam logic [20:0] PLANE1     = 21'h010000;
    localparam logic [15:0] HI_BASE    = 16'hD800;
    localparam logic [15:0] LO_BASE    = 16'hDC00;

    // Smallest code point for two, three and four byte forms.
    localparam logic [20:0] MIN_TWO    = 21'h000080;
    localparam logic [20:0] MIN_THREE  = 21'h000800;
    localparam logic [20:0] MIN_FOUR   = 21'h010000;

    localparam int WIN_DEPTH = 4;

    typedef logic [20:0] code_point_t;
    typedef logic [7:0]  byte_t;

endpackage

`default_nettype wire

### hw/rtl/utf8_to_utf16_transcoder_top.sv
// UTF-8 to UTF-16 transcoder: top level with window, sequencer and output stage.
// Depends on u8u16_pkg for constants and types.
//
// Channel   Dir  Handshake          Payload
// s_ (in)   in   s_tvalid/s_tready  s_tdata = data_byte, s_tlast = final_byte
// m_ (out)  out  m_tvalid/m_tready  m_tdata = code_unit, m_tlast = run_last,
//                                   m_tuser = stream_end
//
// One byte is taken at a time; s_tready is high only while the sequencer waits for a byte.
// Each byte is accepted in ST_IDLE; ST_LEAD then looks at the lead of the window for each
// sequence (the last look finds the window empty or short), ST_CONT merges each continuation
// byte through the shared shift-and-merge unit, ST_CHECK checks each decoded sequence,
// ST_LOW sends the low half of a surrogate pair and ST_FLUSH closes the byte; the sequencer
// waits while m_tready stalls and the output stage is full.
// aresetn is synchronous and active low; it empties the window and the output stage.
`default_nettype none

module utf8_to_utf16_transcoder_top (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,    // [7:0] data_byte
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,    // [15:0] code_unit
    output logic        m_tlast,
    output logic        m_tuser     // [0] stream_end
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LEAD  = 3'd1;
    localparam logic [2:0] ST_CONT  = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_LOW   = 3'd4;
    localparam logic [2:0] ST_FLUSH = 3'd5;

    logic [2:0]              state_reg, state_next;
    u8u16_pkg::byte_t        win_reg  [u8u16_pkg::WIN_DEPTH];
    u8u16_pkg::byte_t        win_next [u8u16_pkg::WIN_DEPTH];
    u8u16_pkg::byte_t        win_drop [u8u16_pkg::WIN_DEPTH];
    logic [2:0]              cnt_reg, cnt_next;
    logic                    fin_reg, fin_next;
    u8u16_pkg::code_point_t  cp_reg, cp_next;
    logic [1:0]              extra_reg, extra_next;
    logic [1:0]              idx_reg, idx_next;
    logic [15:0]             low_reg, low_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [15:0]             pend_unit_reg, pend_unit_next;
    logic                    out_valid_reg, out_valid_next;
    logic [15:0]             out_unit_reg, out_unit_next;
    logic                    out_last_reg, out_last_next;
    logic                    out_end_reg, out_end_next;

    logic                    slot_free;
    logic                    emit_ok;
    logic                    emit_req;
    logic [15:0]             emit_unit;
    logic                    flush_req;
    logic                    drop_req;
    logic [2:0]              drop_k;
    logic [2:0]              lead_len;
    logic                    lead_bad;
    logic [1:0]              lead_extra;
    u8u16_pkg::code_point_t  lead_bits;
    u8u16_pkg::byte_t        cont_byte;
    u8u16_pkg::code_point_t  cp_off;
    logic                    cp_reject;

    assign slot_free = !out_valid_reg || m_tready;
    // A new unit parks in the pending register; the older one moves to the output stage.
    assign emit_ok   = !pend_valid_reg || slot_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_unit_reg;
    assign m_tlast   = out_last_reg;
    assign m_tuser   = out_end_reg;

    // Lead byte decode.
    always_comb begin
        lead_bad   = 1'b0;
        lead_extra = 2'd0;
        lead_bits  = '0;
        if (!win_reg[0][7]) begin
            lead_bits = {14'd0, win_reg[0][6:0]};
        end else if (win_reg[0][7:5] == 3'b110) begin
            lead_extra = 2'd1;
            lead_bits  = {16'd0, win_reg[0][4:0]};
        end else if (win_reg[0][7:4] == 4'b1110) begin
            lead_extra = 2'd2;
            lead_bits  = {17'd0, win_reg[0][3:0]};
        end else if (win_reg[0][7:3] == 5'b11110) begin
            lead_extra = 2'd3;
            lead_bits  = {18'd0, win_reg[0][2:0]};
        end else begin
            lead_bad = 1'b1;
        end
        lead_len = {1'b0, lead_extra} + 3'd1;
    end

    assign cont_byte = win_reg[idx_reg];
    assign cp_off    = cp_reg - u8u16_pkg::PLANE1;

    always_comb begin
        cp_reject = (cp_reg > u8u16_pkg::MAX_CP) ||
                    ((cp_reg >= u8u16_pkg::SURR_FIRST) && (cp_reg <= u8u16_pkg::SURR_LAST));
        case (extra_reg)
            2'd1:    cp_reject = cp_reject || (cp_reg < u8u16_pkg::MIN_TWO);
            2'd2:    cp_reject = cp_reject || (cp_reg < u8u16_pkg::MIN_THREE);
            2'd3:    cp_reject = cp_reject || (cp_reg < u8u16_pkg::MIN_FOUR);
            default: cp_reject = cp_reject;
        endcase
    end

    // Window with the oldest drop_k bytes removed.
    always_comb begin
        for (int i = 0; i < u8u16_pkg::WIN_DEPTH; i++) begin
            if (i + int'(drop_k) < u8u16_pkg::WIN_DEPTH) begin
                win_drop[i] = win_reg[i + int'(drop_k)];
            end else begin
                win_drop[i] = win_reg[i];
            end
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        fin_next   = fin_reg;
        cp_next    = cp_reg;
        extra_next = extra_reg;
        idx_next   = idx_reg;
        low_next   = low_reg;
        emit_req   = 1'b0;
        emit_unit  = u8u16_pkg::REPL_UNIT;
        flush_req  = 1'b0;
        drop_req   = 1'b0;
        drop_k     = 3'd1;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    fin_next   = s_tlast;
                    cnt_next   = cnt_reg + 3'd1;
                    state_next = ST_LEAD;
                end
            end
            ST_LEAD: begin
                if (cnt_reg == 3'd0) begin
                    state_next = ST_FLUSH;
                end else if (lead_bad) begin
                    if (emit_ok) begin
                        emit_req = 1'b1;
                        drop_req = 1'b1;
                        cnt_next = cnt_reg - 3'd1;
                    end
                end else if (cnt_reg < lead_len) begin
                    // Sequence still short: wait for more bytes unless the string has ended.
                    if (!fin_reg) begin
                        state_next = ST_FLUSH;
                    end else if (emit_ok) begin
                        emit_req   = 1'b1;
                        cnt_next   = 3'd0;
                        state_next = ST_FLUSH;
                    end
                end else begin
                    cp_next    = lead_bits;
                    extra_next = lead_extra;
                    idx_next   = 2'd1;
                    state_next = (lead_extra == 2'd0) ? ST_CHECK : ST_CONT;
                end
            end
            ST_CONT: begin
                if (cont_byte[7:6] != 2'b10) begin
                    // Only the lead goes; the rest of the window is scanned again.
                    if (emit_ok) begin
                        emit_req   = 1'b1;
                        drop_req   = 1'b1;
                        cnt_next   = cnt_reg - 3'd1;
                        state_next = ST_LEAD;
                    end
                end else begin
                    cp_next  = {cp_reg[14:0], cont_byte[5:0]};
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == extra_reg) begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (emit_ok) begin
                    emit_req = 1'b1;
                    drop_req = 1'b1;
                    drop_k   = {1'b0, extra_reg} + 3'd1;
                    cnt_next = cnt_reg - drop_k;
                    low_next = u8u16_pkg::LO_BASE | {6'd0, cp_off[9:0]};
                    if (cp_reject) begin
                        emit_unit  = u8u16_pkg::REPL_UNIT;
                        state_next = ST_LEAD;
                    end else if (cp_reg < u8u16_pkg::PLANE1) begin
                        emit_unit  = cp_reg[15:0];
                        state_next = ST_LEAD;
                    end else begin
                        emit_unit  = u8u16_pkg::HI_BASE | {6'd0, cp_off[19:10]};
                        state_next = ST_LOW;
                    end
                end
            end
            ST_LOW: begin
                if (emit_ok) begin
                    emit_req   = 1'b1;
                    emit_unit  = low_reg;
                    state_next = ST_LEAD;
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg || slot_free) begin
                    flush_req  = pend_valid_reg;
                    if (fin_reg) begin
                        cnt_next = 3'd0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Window contents.
    always_comb begin
        for (int i = 0; i < u8u16_pkg::WIN_DEPTH; i++) begin
            win_next[i] = drop_req ? win_drop[i] : win_reg[i];
        end
        if (s_tvalid && s_tready) begin
            win_next[cnt_reg[1:0]] = s_tdata;
        end
    end

    // Pending unit and output stage.
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_unit_next  = pend_unit_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_unit_next   = out_unit_reg;
        out_last_next   = out_last_reg;
        out_end_next    = out_end_reg;
        if (emit_req) begin
            if (pend_valid_reg) begin
                out_valid_next = 1'b1;
                out_unit_next  = pend_unit_reg;
                out_last_next  = 1'b0;
                out_end_next   = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_unit_next  = emit_unit;
        end else if (flush_req) begin
            out_valid_next  = 1'b1;
            out_unit_next   = pend_unit_reg;
            out_last_next   = 1'b1;
            out_end_next    = fin_reg;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= 3'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < u8u16_pkg::WIN_DEPTH; i++) begin
            win_reg[i] <= win_next[i];
        end
        fin_reg       <= fin_next;
        cp_reg        <= cp_next;
        extra_reg     <= extra_next;
        idx_reg       <= idx_next;
        low_reg       <= low_next;
        pend_unit_reg <= pend_unit_next;
        out_unit_reg  <= out_unit_next;
        out_last_reg  <= out_last_next;
        out_end_reg   <= out_end_next;
    end

endmodule

`default_nettype wire

### hw/rtl/u8u16_checker.sv
// Port-level checker for the UTF-8 to UTF-16 transcoder, bound to its top level.
// Depends only on utf8_to_utf16_transcoder_top's port list.
`default_nettype none

module u8u16_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire [7:0]  s_tdata,
    input wire        s_tlast,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [15:0] m_tdata,
    input wire        m_tlast,
    input wire        m_tuser
);

    // The end of the string is always the last unit of its byte's run.
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("stream_end without run_last");

    // One byte at a time: after an input transfer the block is busy.
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // Reset leaves the block waiting for a byte with no result on offer.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("reset left the block busy or the output full");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("result changed under stall");

    // A waiting input transfer keeps its byte and its end mark.
    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
        else $error("input changed while waiting");

endmodule

bind utf8_to_utf16_transcoder_top u8u16_checker u_u8u16_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
